>>> src/rbei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbei_pkg
// Shared types and constants of the rigid body integrator.
// ----------------------------------------------------------------------------
package rbei_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int DT_BITS      = 16;
  localparam int WORD_BITS    = 32;
  localparam int CFG_BITS     = 31;
  localparam int BOUNCE_BITS  = 17;
  localparam int QDEPTH       = 2;
  localparam int IN_TDATA_W   = 184;
  localparam int OUT_TDATA_W  = 200;
  localparam int STATIC_LIMIT = ((1 << FRAC_BITS) * 5 + 999) / 1000;

  typedef enum logic [2:0] {
    OP_ADD_FORCE = 3'd0,
    OP_IMPULSE   = 3'd1,
    OP_INT_FORCE = 3'd2,
    OP_INT_VEL   = 3'd3,
    OP_EDGE      = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_NOP       = 3'd6
  } op_kind_t;

  typedef enum logic [2:0] {
    CFG_INV_MASS    = 3'd0,
    CFG_INV_INERTIA = 3'd1,
    CFG_SCREEN_W    = 3'd2,
    CFG_SCREEN_H    = 3'd3,
    CFG_BOUNCE      = 3'd4,
    CFG_RADIUS      = 3'd5,
    CFG_START_X     = 3'd6,
    CFG_START_Y     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [WORD_BITS-1:0] fx;
    logic signed [WORD_BITS-1:0] fy;
    logic signed [WORD_BITS-1:0] tq;
    logic signed [WORD_BITS-1:0] ax;
    logic signed [WORD_BITS-1:0] ay;
    logic [DT_BITS-1:0]          dt;
  } item_t;

  typedef struct packed {
    logic  full;
    logic  empty;
  } q_stat_t;

endpackage

>>> src/rbei_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbei_front
// Accept input requests, unpack the fields and classify the operation.
// ----------------------------------------------------------------------------
module rbei_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rbei_pkg::IN_TDATA_W-1:0] in_tdata,
  input  rbei_pkg::q_stat_t              q_stat,
  output logic                           push,
  output rbei_pkg::item_t                item
);
  import rbei_pkg::*;

  op_kind_t kind;

  always_comb begin
    unique case (in_tdata[2:0])
      3'd0:    kind = OP_ADD_FORCE;
      3'd1:    kind = OP_IMPULSE;
      3'd2:    kind = OP_INT_FORCE;
      3'd3:    kind = OP_INT_VEL;
      3'd4:    kind = OP_EDGE;
      3'd5:    kind = OP_CLEAR;
      default: kind = OP_NOP;
    endcase
  end

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  always_comb begin
    item.kind = kind;
    item.fx   = in_tdata[34:3];
    item.fy   = in_tdata[66:35];
    item.tq   = in_tdata[98:67];
    item.ax   = in_tdata[130:99];
    item.ay   = in_tdata[162:131];
    item.dt   = in_tdata[178:163];
  end

endmodule

>>> src/rbei_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbei_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module rbei_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rbei_pkg::item_t   item_in,
  input  logic              pop,
  output rbei_pkg::item_t   item_out,
  output rbei_pkg::q_stat_t q_stat
);
  import rbei_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  item_t           mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign item_out     = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == (PW+1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

>>> src/rbei_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbei_back
// Execute operations on the body state with one shared multiplier.
// ----------------------------------------------------------------------------
module rbei_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [31:0]                     cfg_data,
  input  rbei_pkg::q_stat_t               q_stat,
  input  rbei_pkg::item_t                 head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rbei_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rbei_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_OUT} state_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic word_t sat_sum(input logic signed [WORD_BITS:0] s);
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_add(input word_t x, input word_t y);
    return sat_sum({x[WORD_BITS-1], x} + {y[WORD_BITS-1], y});
  endfunction

  function automatic word_t sat_sub(input word_t x, input word_t y);
    return sat_sum({x[WORD_BITS-1], x} - {y[WORD_BITS-1], y});
  endfunction

  state_t                  state_r;
  item_t                   item_r;
  logic [2:0]              step_r;
  logic [2*WORD_BITS-1:0]  prod_r;
  logic                    neg_r, sh_dt_r;
  word_t                   tmp_r;
  word_t                   px_r, py_r, vx_r, vy_r, hd_r, sp_r, fsx_r, fsy_r, tsum_r;
  logic [CFG_BITS-1:0]     inv_mass_r, inv_inertia_r, width_r, height_r, radius_r;
  logic [BOUNCE_BITS-1:0]  bounce_r;
  logic                    is_static;

  assign is_static = (inv_mass_r < CFG_BITS'(STATIC_LIMIT));
  assign cfg_ready = 1'b1;
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r    <= CFG_BITS'(65536);
      inv_inertia_r <= CFG_BITS'(65536);
      width_r       <= CFG_BITS'(52428800);
      height_r      <= CFG_BITS'(39321600);
      bounce_r      <= BOUNCE_BITS'(65536);
      radius_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INV_MASS:    inv_mass_r    <= cfg_data[CFG_BITS-1:0];
        CFG_INV_INERTIA: inv_inertia_r <= cfg_data[CFG_BITS-1:0];
        CFG_SCREEN_W:    width_r       <= cfg_data[CFG_BITS-1:0];
        CFG_SCREEN_H:    height_r      <= cfg_data[CFG_BITS-1:0];
        CFG_BOUNCE:      bounce_r      <= cfg_data[BOUNCE_BITS-1:0];
        CFG_RADIUS:      radius_r      <= cfg_data[CFG_BITS-1:0];
        CFG_START_X, CFG_START_Y: ;
      endcase
    end
  end

  // operand select
  logic signed [WORD_BITS:0] op_a, op_b, na, nb;
  logic                      last_step, use_dt;
  logic [WORD_BITS-1:0]      ma, mb;

  always_comb begin
    op_a = '0;
    op_b = '0;
    use_dt = 1'b0;
    last_step = 1'b1;
    unique case (item_r.kind)
      OP_IMPULSE: begin
        last_step = (step_r == 3'd4);
        unique case (step_r)
          3'd0:    begin op_a = {item_r.fx[31], item_r.fx}; op_b = {2'b0, inv_mass_r}; end
          3'd1:    begin op_a = {item_r.fy[31], item_r.fy}; op_b = {2'b0, inv_mass_r}; end
          3'd2:    begin op_a = {item_r.ax[31], item_r.ax}; op_b = {item_r.fy[31], item_r.fy}; end
          3'd3:    begin op_a = {item_r.ay[31], item_r.ay}; op_b = {item_r.fx[31], item_r.fx}; end
          default: begin op_a = {tmp_r[31], tmp_r}; op_b = {2'b0, inv_inertia_r}; end
        endcase
      end
      OP_INT_FORCE: begin
        last_step = (step_r == 3'd5);
        use_dt = step_r[0];
        unique case (step_r)
          3'd0:    begin op_a = {fsx_r[31], fsx_r}; op_b = {2'b0, inv_mass_r}; end
          3'd2:    begin op_a = {fsy_r[31], fsy_r}; op_b = {2'b0, inv_mass_r}; end
          3'd4:    begin op_a = {tsum_r[31], tsum_r}; op_b = {2'b0, inv_inertia_r}; end
          default: begin op_a = {tmp_r[31], tmp_r}; op_b = {17'b0, item_r.dt}; end
        endcase
      end
      OP_INT_VEL: begin
        last_step = (step_r == 3'd2);
        use_dt = 1'b1;
        op_b = {17'b0, item_r.dt};
        unique case (step_r)
          3'd0:    op_a = {vx_r[31], vx_r};
          3'd1:    op_a = {vy_r[31], vy_r};
          default: op_a = {sp_r[31], sp_r};
        endcase
      end
      OP_EDGE: begin
        last_step = (step_r == 3'd1);
        op_a = step_r[0] ? {vy_r[31], vy_r} : {vx_r[31], vx_r};
        op_b = {16'b0, bounce_r};
      end
      default: ;
    endcase
    na = ~op_a + 33'sd1;
    nb = ~op_b + 33'sd1;
    ma = op_a[WORD_BITS] ? na[WORD_BITS-1:0] : op_a[WORD_BITS-1:0];
    mb = op_b[WORD_BITS] ? nb[WORD_BITS-1:0] : op_b[WORD_BITS-1:0];
  end

  // shift, saturate and sign the product
  logic [2*WORD_BITS-1:0] q, lim, qs;
  word_t                  mres, vbounce, p_ax, new_p;
  logic [CFG_BITS-1:0]    edge_ax;
  logic signed [WORD_BITS+1:0] pm, pp;
  logic                   hit_lo, hit_hi;
  logic [WORD_BITS:0]     edge_sub;

  always_comb begin
    q   = sh_dt_r ? (prod_r >> DT_BITS) : (prod_r >> FRAC_BITS);
    lim = neg_r ? (2*WORD_BITS)'(WMIN[WORD_BITS-1:0]) : (2*WORD_BITS)'(WMAX);
    qs  = (q > lim) ? lim : q;
    mres = neg_r ? (~qs[WORD_BITS-1:0] + 32'd1) : qs[WORD_BITS-1:0];
    vbounce = (mres == WMIN) ? WMAX : (~mres + 32'sd1);
    p_ax    = step_r[0] ? py_r : px_r;
    edge_ax = step_r[0] ? height_r : width_r;
    pm = {{2{p_ax[31]}}, p_ax} - {3'b0, radius_r};
    pp = {{2{p_ax[31]}}, p_ax} + {3'b0, radius_r};
    hit_lo = pm[WORD_BITS+1] || (pm == '0);
    hit_hi = (pp >= $signed({3'b0, edge_ax}));
    edge_sub = {2'b0, edge_ax} - {2'b0, radius_r};
    new_p = hit_lo ? {1'b0, radius_r} : edge_sub[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      out_tvalid <= 1'b0;
      px_r <= '0; py_r <= '0; vx_r <= '0; vy_r <= '0; hd_r <= '0; sp_r <= '0;
      fsx_r <= '0; fsy_r <= '0; tsum_r <= '0;
    end else begin
      if (out_tvalid && out_tready && state_r != S_OUT) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            item_r  <= head;
            step_r  <= '0;
            state_r <= S_OUT;
            unique case (head.kind)
              OP_ADD_FORCE: begin
                fsx_r  <= sat_add(fsx_r, head.fx);
                fsy_r  <= sat_add(fsy_r, head.fy);
                tsum_r <= sat_add(tsum_r, head.tq);
              end
              OP_CLEAR: begin
                fsx_r <= '0; fsy_r <= '0; tsum_r <= '0;
              end
              OP_IMPULSE, OP_INT_FORCE, OP_INT_VEL: begin
                if (!is_static) state_r <= S_MUL;
              end
              OP_EDGE: begin
                if (radius_r != '0) state_r <= S_MUL;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= ma * mb;
          neg_r   <= op_a[WORD_BITS] ^ op_b[WORD_BITS];
          sh_dt_r <= use_dt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          unique case (item_r.kind)
            OP_IMPULSE: begin
              unique case (step_r)
                3'd0:    vx_r  <= sat_add(vx_r, mres);
                3'd1:    vy_r  <= sat_add(vy_r, mres);
                3'd2:    tmp_r <= mres;
                3'd3:    tmp_r <= sat_sub(tmp_r, mres);
                default: sp_r  <= sat_add(sp_r, mres);
              endcase
            end
            OP_INT_FORCE: begin
              unique case (step_r)
                3'd1:    vx_r  <= sat_add(vx_r, mres);
                3'd3:    vy_r  <= sat_add(vy_r, mres);
                3'd5: begin
                  sp_r <= sat_add(sp_r, mres);
                  fsx_r <= '0; fsy_r <= '0; tsum_r <= '0;
                end
                default: tmp_r <= mres;
              endcase
            end
            OP_INT_VEL: begin
              unique case (step_r)
                3'd0:    px_r <= sat_add(px_r, mres);
                3'd1:    py_r <= sat_add(py_r, mres);
                default: hd_r <= sat_add(hd_r, mres);
              endcase
            end
            OP_EDGE: begin
              if (hit_lo || hit_hi) begin
                if (step_r[0]) begin
                  py_r <= new_p;
                  vy_r <= vbounce;
                end else begin
                  px_r <= new_p;
                  vx_r <= vbounce;
                end
              end
            end
            default: ;
          endcase
          step_r  <= step_r + 3'd1;
          state_r <= last_step ? S_OUT : S_MUL;
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {7'b0, is_static, sp_r, hd_r, vy_r, vx_r, py_r, px_r};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/rigid_body_euler_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator
// Fixed-point 2D rigid body state with semi-implicit Euler integration.
// ----------------------------------------------------------------------------
// One request yields one result carrying the updated state. Requests are
// handled one at a time by a back end with a single 32x32 multiplier; each
// product passes a multiply state, then a shift/saturate/accumulate state.
// Add force, clear and unused codes use no multiply; edge collide,
// integrate velocities, impulse and integrate forces run their products in
// turn; a static body skips the multiplies of impulse and both integrations,
// and edge collide skips them when the radius is zero. A two-entry queue
// lets the front accept requests while the back end works or the result
// waits.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], force_x, force_y, torque_in, arm_x, arm_y, time_step, zero pad
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x_out, pos_y_out, vel_x_out, vel_y_out, heading_out, spin_out,
  // is_static_out, zero pad
  output logic [199:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import rbei_pkg::*;

  q_stat_t q_stat;
  item_t   f_item, q_item;
  logic    push, pop;

  rbei_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .item      (f_item)
  );

  rbei_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .pop      (pop),
    .item_out (q_item),
    .q_stat   (q_stat)
  );

  rbei_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .head       (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/rbei_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbei_checker
// Port-level checks of the rigid body integrator.
// ----------------------------------------------------------------------------
module rbei_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata
);

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("ports not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input ready dropped without a request");

endmodule

bind rigid_body_euler_integrator rbei_checker u_rbei_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
